[hdl/tcce_pkg.sv]
// Shared types and constants for the text console cursor engine.
// No dependencies; the interfaces, the core and the testbench import this package.

package tcce_pkg;

    // Payload widths of the item channels
    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int ATTR_W     = 8;
    localparam int POS_W      = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;
    localparam int MARGIN_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_WRITE = 2'd3
    } t_req;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEXT_COLOR = 2'd0,
        CFG_BACK_COLOR = 2'd1,
        CFG_MIN_COL    = 2'd2
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_COPY,
        ST_FILL,
        ST_RESP
    } t_state;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS          = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB         = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF          = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FF          = 8'd12;
    localparam logic [CHAR_W-1:0] CH_CR          = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE       = 8'h20;
    localparam logic [CHAR_W-1:0] CH_FIRST_PRINT = 8'd32;
    localparam logic [CHAR_W-1:0] CH_LAST_PRINT  = 8'd126;
    localparam logic [CHAR_W-1:0] CH_DEL         = 8'd127;

    // Cell value after power-up and the upper bound of a margin write
    localparam logic [CELL_W-1:0]     RESET_CELL   = 16'h0F20;
    localparam logic [CFG_DATA_W-1:0] MARGIN_LIMIT = 5'd24;

endpackage

[hdl/tcce_if.sv]
// Handshake channels of the text console cursor engine: request items,
// response items and configuration writes. Depends on tcce_pkg.

interface tcce_req_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [ATTR_W-1:0] cell_attr;

    modport source (output valid, req_type, char_code, row, column, cell_attr,
                    input ready);
    modport sink   (input valid, req_type, char_code, row, column, cell_attr,
                    output ready);
endinterface

interface tcce_rsp_if import tcce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;

    modport source (output valid, cursor_row, cursor_col, cursor_pos, cell_data, scrolled,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_pos, cell_data, scrolled,
                    output ready);
endinterface

interface tcce_cfg_if import tcce_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/text_console_cursor_engine_core.sv]
// Text console cursor engine: character-cell screen store, cursor and edit sequencer.
// Depends on tcce_pkg, the channel interfaces in tcce_if and the RAM in tcce_ram.
// Sequence: print, tab, backspace, read and raw write are accepted, then the response
//   register loads; a new line that scrolls first copies the rows up and blanks the
//   bottom row, and clear and form feed first blank the console rows.
// Throughput: one item at a time; the single RAM write port moves one cell per cycle.
// Reset: synchronous; afterwards a clearing pass writes all rows*cols cells
//   with requests held off; configuration writes are taken throughout.

module text_console_cursor_engine_core import tcce_pkg::*; #(
    parameter int SCREEN_ROWS = 25,
    parameter int SCREEN_COLS = 80,
    parameter int FIRST_ROW   = 1,
    parameter int TAB_STOP    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcce_req_if.sink    i_req,
    tcce_cfg_if.sink    i_cfg,
    tcce_rsp_if.source  o_rsp
);

    // Geometry
    localparam int DEPTH     = SCREEN_ROWS * SCREEN_COLS;
    localparam int AW        = $clog2(DEPTH);
    localparam int PW        = $clog2(DEPTH + 1);
    localparam int RW        = $clog2(SCREEN_ROWS);
    localparam int CW        = $clog2(SCREEN_COLS);
    localparam int TOP_ROW   = (FIRST_ROW < SCREEN_ROWS) ? FIRST_ROW : SCREEN_ROWS - 1;
    localparam int LAST_ROW  = SCREEN_ROWS - 1;
    localparam int LAST_COL  = SCREEN_COLS - 1;
    localparam int TOP_BASE  = TOP_ROW * SCREEN_COLS;
    localparam int LAST_BASE = LAST_ROW * SCREEN_COLS;

    localparam logic              HAS_SCROLL   = (TOP_ROW < LAST_ROW);
    localparam logic [RW-1:0]     TOP_R        = RW'(TOP_ROW);
    localparam logic [RW-1:0]     LAST_R       = RW'(LAST_ROW);
    localparam logic [CW-1:0]     LAST_C       = CW'(LAST_COL);
    localparam logic [PW-1:0]     DEPTH_P      = PW'(DEPTH);
    localparam logic [PW-1:0]     END_P        = PW'(DEPTH - 1);
    localparam logic [PW-1:0]     COLS_P       = PW'(SCREEN_COLS);
    localparam logic [PW-1:0]     TOP_BASE_P   = PW'(TOP_BASE);
    localparam logic [PW-1:0]     LAST_BASE_P  = PW'(LAST_BASE);
    localparam logic [PW-1:0]     SCROLL_SRC_P = PW'(TOP_BASE + SCREEN_COLS);
    localparam logic [7:0]        LAST_COL_8   = 8'(LAST_COL);

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        cell_addr = AW'(r) * AW'(SCREEN_COLS) + AW'(c);
    endfunction

    // Control registers
    t_state                r_state, n_state;
    logic [PW-1:0]         r_ptr;
    logic                  r_cp_pend;
    logic                  r_out_vld;
    logic [RW-1:0]         r_cur_row, n_cur_row;
    logic [CW-1:0]         r_cur_col, n_cur_col;
    logic [COLOR_W-1:0]    r_text_color;
    logic [COLOR_W-1:0]    r_back_color;
    logic [MARGIN_W-1:0]   r_min_col;

    // Payload registers
    logic [AW-1:0]         r_wr_ptr;
    logic [CELL_W-1:0]     r_fill_val;
    logic                  r_scrolled;
    logic                  r_is_read;
    logic [ROW_W-1:0]      r_out_row;
    logic [COL_W-1:0]      r_out_col;
    logic [POS_W-1:0]      r_out_pos;
    logic [CELL_W-1:0]     r_out_data;
    logic                  r_out_scr;

    // Tab stop table: next stop for every column, saturated at the last column
    logic [CW-1:0] tab_next [SCREEN_COLS];
    for (genvar g = 0; g < SCREEN_COLS; g++) begin : g_tab
        localparam int NXT = (g / TAB_STOP + 1) * TAB_STOP;
        assign tab_next[g] = CW'((NXT < SCREEN_COLS) ? NXT : LAST_COL);
    end

    // Common values
    logic                req_acc;
    logic [CW-1:0]       margin;
    logic                col_dec;
    logic [CW-1:0]       col_left;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       left_addr;
    logic [AW-1:0]       in_addr;
    logic                in_ok;
    logic                printable;
    logic [CELL_W-1:0]   blank;
    logic [PW-1:0]       copy_dst;
    logic                copy_more;

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && (r_state == ST_IDLE);

    assign margin    = (8'(r_min_col) < LAST_COL_8) ? CW'(r_min_col) : LAST_C;
    assign col_dec   = (r_cur_col > margin);
    assign col_left  = col_dec ? r_cur_col - 1'b1 : r_cur_col;
    assign cur_addr  = cell_addr(r_cur_row, r_cur_col);
    assign left_addr = cur_addr - AW'(col_dec);
    assign in_ok     = (i_req.row < SCREEN_ROWS) && (i_req.column < SCREEN_COLS);
    assign in_addr   = cell_addr(RW'(i_req.row), CW'(i_req.column));
    assign printable = (i_req.char_code >= CH_FIRST_PRINT) &&
                       (i_req.char_code <= CH_LAST_PRINT);
    assign blank     = {r_back_color, r_text_color, CH_SPACE};
    assign copy_dst  = r_ptr - COLS_P;
    assign copy_more = (r_ptr != DEPTH_P);

    // Request decode: cursor update and the single cell access of the item
    logic                d_wr_en;
    logic [AW-1:0]       d_wr_addr;
    logic [CELL_W-1:0]   d_wr_data;
    logic                d_rd_en;
    logic                d_fill;
    logic [PW-1:0]       d_fill_start;
    logic                d_scroll;
    logic                d_is_read;
    logic                put_nl;

    always_comb begin
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        d_wr_en      = 1'b0;
        d_wr_addr    = cur_addr;
        d_wr_data    = blank;
        d_rd_en      = 1'b0;
        d_fill       = 1'b0;
        d_fill_start = TOP_BASE_P;
        d_scroll     = 1'b0;
        d_is_read    = 1'b0;
        put_nl       = 1'b0;
        case (t_req'(i_req.req_type))
            REQ_PUT: begin
                if (printable) begin
                    d_wr_en   = 1'b1;
                    d_wr_data = {r_back_color, r_text_color, i_req.char_code};
                    if (r_cur_col == LAST_C) begin
                        put_nl = 1'b1;
                    end else begin
                        n_cur_col = r_cur_col + 1'b1;
                    end
                end else begin
                    case (i_req.char_code)
                        CH_DEL: begin
                            n_cur_col = col_left;
                            d_wr_en   = 1'b1;
                            d_wr_addr = left_addr;
                        end
                        CH_BS: begin
                            n_cur_col = col_left;
                            d_wr_en   = 1'b1;
                        end
                        CH_TAB: begin
                            n_cur_col = tab_next[r_cur_col];
                        end
                        CH_LF, CH_CR: begin
                            put_nl = 1'b1;
                        end
                        CH_FF: begin
                            n_cur_row    = TOP_R;
                            n_cur_col    = margin;
                            d_fill       = 1'b1;
                            d_fill_start = TOP_BASE_P + PW'(margin);
                        end
                        default: begin
                        end
                    endcase
                end
                // new line: scroll on the bottom row, else advance the row
                if (put_nl) begin
                    if (r_cur_row >= LAST_R) begin
                        n_cur_row = LAST_R;
                        d_scroll  = HAS_SCROLL;
                    end else begin
                        n_cur_row = r_cur_row + 1'b1;
                    end
                    n_cur_col = margin;
                end
            end
            REQ_CLEAR: begin
                n_cur_row = TOP_R;
                n_cur_col = '0;
                d_fill    = 1'b1;
            end
            REQ_READ: begin
                d_rd_en   = in_ok;
                d_is_read = in_ok;
            end
            REQ_WRITE: begin
                d_wr_en   = in_ok;
                d_wr_addr = in_addr;
                d_wr_data = {i_req.cell_attr, i_req.char_code};
            end
            default: begin
            end
        endcase
    end

    // Next state
    logic out_load;
    assign out_load = (r_state == ST_RESP) && (!r_out_vld || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (r_ptr == END_P) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_acc) begin
                    if (d_scroll) begin
                        n_state = ST_COPY;
                    end else if (d_fill) begin
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_COPY: begin
                if (!copy_more) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_ptr == END_P) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // RAM port control per state
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [CELL_W-1:0]   rd_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ptr[AW-1:0];
        wr_data = r_fill_val;
        rd_en   = 1'b0;
        rd_addr = r_ptr[AW-1:0];
        case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_data = RESET_CELL;
            end
            ST_IDLE: begin
                wr_en   = req_acc && d_wr_en;
                wr_addr = d_wr_addr;
                wr_data = d_wr_data;
                rd_en   = req_acc && d_rd_en;
                rd_addr = in_addr;
            end
            ST_COPY: begin
                wr_en   = r_cp_pend;
                wr_addr = r_wr_ptr;
                wr_data = rd_data;
                rd_en   = copy_more;
            end
            ST_FILL: begin
                wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH),
        .ADDR_W(AW)
    ) u_screen (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Control state, cursor and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_ptr        <= '0;
            r_cp_pend    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_cur_row    <= TOP_R;
            r_cur_col    <= '0;
            r_text_color <= 4'd15;
            r_back_color <= 4'd0;
            r_min_col    <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_TEXT_COLOR: r_text_color <= i_cfg.data[COLOR_W-1:0];
                    CFG_BACK_COLOR: r_back_color <= i_cfg.data[COLOR_W-1:0];
                    CFG_MIN_COL: begin
                        if (i_cfg.data < MARGIN_LIMIT) begin
                            r_min_col <= i_cfg.data;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                ST_IDLE: begin
                    if (req_acc) begin
                        r_cur_row <= n_cur_row;
                        r_cur_col <= n_cur_col;
                        r_cp_pend <= 1'b0;
                        r_ptr     <= d_scroll ? SCROLL_SRC_P : d_fill_start;
                    end
                end
                ST_COPY: begin
                    r_cp_pend <= copy_more;
                    r_ptr     <= copy_more ? r_ptr + 1'b1 : LAST_BASE_P;
                end
                ST_FILL: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                default: begin
                end
            endcase

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Item payload and response register
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_scrolled <= d_scroll;
            r_is_read  <= d_is_read;
            r_fill_val <= blank;
        end
        if (r_state == ST_COPY) begin
            r_wr_ptr <= copy_dst[AW-1:0];
        end
        if (out_load) begin
            r_out_row  <= ROW_W'(r_cur_row);
            r_out_col  <= COL_W'(r_cur_col);
            r_out_pos  <= POS_W'(cur_addr);
            r_out_data <= r_is_read ? rd_data : '0;
            r_out_scr  <= r_scrolled;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.cursor_row = r_out_row;
    assign o_rsp.cursor_col = r_out_col;
    assign o_rsp.cursor_pos = r_out_pos;
    assign o_rsp.cell_data  = r_out_data;
    assign o_rsp.scrolled   = r_out_scr;

    // Cursor stays inside the console region
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row >= TOP_ROW) && (r_cur_row < SCREEN_ROWS))
        else $error("cursor row left the console region");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col < SCREEN_COLS)
        else $error("cursor column beyond the screen");

    // One item at a time: no request taken right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !i_req.ready)
        else $error("request accepted while an item is in work");

    // A scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.scrolled) |-> (o_rsp.cursor_row == ROW_W'(LAST_ROW)))
        else $error("scroll reported off the bottom row");

    // Cell writes stay inside the store
    a_wr_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr < DEPTH))
        else $error("screen write beyond the store");

endmodule

[hdl/tcce_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low. No dependencies.

module tcce_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[dv/text_console_cursor_engine_core_test.sv]
// Self-checking testbench for text_console_cursor_engine_core: random and directed
// requests, a console model in a scoreboard class, random stalls on both sides.
// Depends on tcce_pkg, the channel interfaces in tcce_if and the block itself.

module text_console_cursor_engine_core_test;
    import tcce_pkg::*;

    localparam int SCREEN_ROWS = 25;
    localparam int SCREEN_COLS = 80;
    localparam int FIRST_ROW   = 1;
    localparam int TAB_STOP    = 8;
    localparam int TOP_ROW     = (FIRST_ROW < SCREEN_ROWS) ? FIRST_ROW : SCREEN_ROWS - 1;
    localparam int LAST_ROW    = SCREEN_ROWS - 1;
    localparam int LAST_COL    = SCREEN_COLS - 1;
    localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 122;
    // Every item a full scroll plus worst stalls, several times over
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int SETTLE      = 2100;

    typedef struct packed {
        t_req              kind;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  column;
        logic [ATTR_W-1:0] cell_attr;
    } request_t;

    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } response_t;

    // Console model plus the queue of cursor results still to arrive
    class console_scoreboard;
        logic [CELL_W-1:0] screen [CELLS];
        int unsigned       cur_row;
        int unsigned       cur_col;
        logic [3:0]        fg;
        logic [3:0]        bg;
        int unsigned       margin_reg;
        response_t         awaited_rsp [$];
        int unsigned       errors;

        function new();
            foreach (screen[i]) screen[i] = RESET_CELL;
            cur_row    = TOP_ROW;
            cur_col    = 0;
            fg         = 4'hF;
            bg         = 4'h0;
            margin_reg = 0;
            errors     = 0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TEXT_COLOR: fg = value[3:0];
                CFG_BACK_COLOR: bg = value[3:0];
                CFG_MIN_COL: begin
                    // out-of-range margin writes are dropped
                    if (value < MARGIN_LIMIT) margin_reg = value;
                end
                default: ;
            endcase
        endfunction

        function int unsigned margin_col();
            return (margin_reg < LAST_COL) ? margin_reg : LAST_COL;
        endfunction

        function logic [CELL_W-1:0] blank_cell();
            return {bg, fg, CH_SPACE};
        endfunction

        function void put_cell(int unsigned r, int unsigned c, logic [CELL_W-1:0] v);
            if (r < SCREEN_ROWS && c < SCREEN_COLS) screen[r * SCREEN_COLS + c] = v;
        endfunction

        function void blank_span(int unsigned r, int unsigned from);
            for (int unsigned c = from; c < SCREEN_COLS; c++) put_cell(r, c, blank_cell());
        endfunction

        // New line; scrolls the console rows when on the bottom row
        function bit line_feed();
            bit moved;
            moved = 1'b0;
            if (cur_row >= LAST_ROW) begin
                if (TOP_ROW < LAST_ROW) begin
                    for (int i = TOP_ROW * SCREEN_COLS; i < LAST_ROW * SCREEN_COLS; i++)
                        screen[i] = screen[i + SCREEN_COLS];
                    blank_span(LAST_ROW, 0);
                    moved = 1'b1;
                end
                cur_row = LAST_ROW;
            end else begin
                cur_row++;
            end
            cur_col = margin_col();
            return moved;
        endfunction

        function bit print_code(logic [CHAR_W-1:0] ch);
            int unsigned stop;
            if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
                put_cell(cur_row, cur_col, {bg, fg, ch});
                if (cur_col >= LAST_COL) return line_feed();
                cur_col++;
                return 1'b0;
            end
            case (ch)
                CH_DEL: begin
                    if (cur_col > margin_col()) cur_col--;
                    put_cell(cur_row, cur_col, blank_cell());
                end
                CH_BS: begin
                    put_cell(cur_row, cur_col, blank_cell());
                    if (cur_col > margin_col()) cur_col--;
                end
                CH_TAB: begin
                    stop    = (cur_col / TAB_STOP + 1) * TAB_STOP;
                    cur_col = (stop < SCREEN_COLS) ? stop : LAST_COL;
                end
                CH_LF, CH_CR: return line_feed();
                CH_FF: begin
                    blank_span(TOP_ROW, margin_col());
                    for (int unsigned r = TOP_ROW + 1; r < SCREEN_ROWS; r++) blank_span(r, 0);
                    cur_row = TOP_ROW;
                    cur_col = margin_col();
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        // Accepted request: update the model and queue the cursor result it causes
        function void note_request(request_t rq);
            response_t   want;
            int unsigned r;
            int unsigned c;
            want = '0;
            r    = rq.row;
            c    = rq.column;
            case (rq.kind)
                REQ_PUT: want.scrolled = print_code(rq.char_code);
                REQ_CLEAR: begin
                    for (int unsigned k = TOP_ROW; k < SCREEN_ROWS; k++) blank_span(k, 0);
                    cur_row = TOP_ROW;
                    cur_col = 0;
                end
                REQ_READ: begin
                    if (r < SCREEN_ROWS && c < SCREEN_COLS)
                        want.cell_data = screen[r * SCREEN_COLS + c];
                end
                default: put_cell(r, c, {rq.cell_attr, rq.char_code});
            endcase
            want.cursor_row = cur_row[ROW_W-1:0];
            want.cursor_col = cur_col[COL_W-1:0];
            want.cursor_pos = POS_W'(cur_row * SCREEN_COLS + cur_col);
            awaited_rsp.push_back(want);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_response(response_t got);
            response_t want;
            if (awaited_rsp.size() == 0) begin
                report($sformatf("unexpected result row %0d col %0d", got.cursor_row,
                                 got.cursor_col));
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.cursor_row !== want.cursor_row)
                report($sformatf("cursor_row %0d, want %0d", got.cursor_row, want.cursor_row));
            if (got.cursor_col !== want.cursor_col)
                report($sformatf("cursor_col %0d, want %0d", got.cursor_col, want.cursor_col));
            if (got.cursor_pos !== want.cursor_pos)
                report($sformatf("cursor_pos %0d, want %0d", got.cursor_pos, want.cursor_pos));
            if (got.cell_data !== want.cell_data)
                report($sformatf("cell_data %h, want %h", got.cell_data, want.cell_data));
            if (got.scrolled !== want.scrolled)
                report($sformatf("scrolled %b, want %b", got.scrolled, want.scrolled));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned cycle_count = 0;
    int unsigned idle_pct;
    int unsigned rsp_hold;

    console_scoreboard sb;

    tcce_req_if req_ch ();
    tcce_cfg_if cfg_ch ();
    tcce_rsp_if rsp_ch ();

    text_console_cursor_engine_core #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .SCREEN_COLS (SCREEN_COLS),
        .FIRST_ROW   (FIRST_ROW),
        .TAB_STOP    (TAB_STOP)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .i_cfg   (cfg_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result ready with random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || idle_pct == 0) begin
            rsp_ch.ready <= 1'b1;
            rsp_hold = 0;
        end else if (rsp_hold != 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold = $urandom_range(0, 4);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response({rsp_ch.cursor_row, rsp_ch.cursor_col, rsp_ch.cursor_pos,
                               rsp_ch.cell_data, rsp_ch.scrolled});
    end

    function automatic request_t random_request();
        request_t rq;
        rq.kind      = t_req'($urandom_range(0, 3));
        rq.char_code = CHAR_W'($urandom_range(0, 255));
        rq.row       = ROW_W'($urandom_range(0, 31));
        rq.column    = COL_W'($urandom_range(0, 127));
        rq.cell_attr = ATTR_W'($urandom_range(0, 255));
        return rq;
    endfunction

    function automatic logic [CHAR_W-1:0] ignored_code();
        logic [CHAR_W-1:0] ch;
        do ch = CHAR_W'($urandom_range(0, 255));
        while (ch inside {[CH_FIRST_PRINT:CH_LAST_PRINT], CH_BS, CH_TAB, CH_LF, CH_FF,
                          CH_CR, CH_DEL});
        return ch;
    endfunction

    // One request item; valid stays high afterwards unless the next item idles first
    task automatic send_request(input request_t rq);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rq.kind;
        req_ch.char_code <= rq.char_code;
        req_ch.row       <= rq.row;
        req_ch.column    <= rq.column;
        req_ch.cell_attr <= rq.cell_attr;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(rq);
    endtask

    task automatic issue(input t_req kind, input logic [CHAR_W-1:0] ch,
                         input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                         input logic [ATTR_W-1:0] a);
        send_request('{kind, ch, r, c, a});
    endtask

    task automatic put(input logic [CHAR_W-1:0] ch);
        request_t rq;
        rq           = random_request();
        rq.kind      = REQ_PUT;
        rq.char_code = ch;
        send_request(rq);
    endtask

    // Stop requests and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Writes all three registers back to back; only called with the block idle
    task automatic set_console_regs(input logic [CFG_DATA_W-1:0] text,
                                    input logic [CFG_DATA_W-1:0] back,
                                    input logic [CFG_DATA_W-1:0] margin);
        t_cfg_idx              idx  [3];
        logic [CFG_DATA_W-1:0] vals [3];
        idx  = '{CFG_TEXT_COLOR, CFG_BACK_COLOR, CFG_MIN_COL};
        vals = '{text, back, margin};
        for (int k = 0; k < 3; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= vals[k];
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
            sb.write_register(idx[k], vals[k]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly text lines ending in a new line, mixed with edits, reads and raw writes
    task automatic run_phase(input int quota);
        int       sent;
        int       len;
        int       pick;
        request_t rq;
        sent = 0;
        while (sent < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                issue(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
                      COL_W'($urandom_range(0, 127)), ATTR_W'($urandom_range(0, 255)));
                sent++;
            end else if (pick < 5) begin
                put(CH_FF);
                sent++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90)
                                                  : $urandom_range(0, 20);
                for (int k = 0; k < len && sent < quota; k++) begin
                    pick = $urandom_range(0, 99);
                    rq   = random_request();
                    rq.kind = REQ_PUT;
                    if (pick < 70) begin
                        rq.char_code = CHAR_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT));
                    end else if (pick < 76) begin
                        rq.char_code = CH_TAB;
                    end else if (pick < 80) begin
                        rq.char_code = CH_BS;
                    end else if (pick < 84) begin
                        rq.char_code = CH_DEL;
                    end else if (pick < 90) begin
                        // read back, half the time on the cursor row up to the cursor
                        rq.kind = REQ_READ;
                        if ($urandom_range(0, 1) != 0) begin
                            rq.row    = ROW_W'(sb.cur_row);
                            rq.column = COL_W'($urandom_range(0, sb.cur_col));
                        end
                    end else if (pick < 95) begin
                        rq.kind = REQ_WRITE;
                    end else begin
                        rq.char_code = ignored_code();
                    end
                    send_request(rq);
                    sent++;
                end
                // a few lines are left open
                if (sent < quota && $urandom_range(0, 9) != 0) begin
                    put(($urandom_range(0, 1) != 0) ? CH_LF : CH_CR);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        idle_pct          = 20;
        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= REQ_PUT;
        req_ch.char_code <= '0;
        req_ch.row       <= '0;
        req_ch.column    <= '0;
        req_ch.cell_attr <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_TEXT_COLOR;
        cfg_ch.data      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: store edges, out-of-range cells, every control code
        issue(REQ_READ, 8'h00, 5'd0, 7'd0, 8'h00);
        issue(REQ_READ, 8'hFF, 5'd24, 7'd79, 8'hFF);
        issue(REQ_READ, 8'h55, 5'd31, 7'd127, 8'hAA);
        issue(REQ_READ, 8'hAA, 5'd5, 7'd80, 8'h55);
        issue(REQ_WRITE, 8'hFF, 5'd0, 7'd0, 8'hFF);
        issue(REQ_WRITE, 8'h41, 5'd25, 7'd0, 8'h0E);
        issue(REQ_WRITE, 8'h42, 5'd24, 7'd127, 8'h70);
        issue(REQ_READ, 8'h00, 5'd0, 7'd0, 8'h00);
        put(CH_DEL);
        put(CH_BS);
        put(CH_FIRST_PRINT);
        put(CH_LAST_PRINT);
        put(CH_DEL);
        put(CH_BS);
        put(CH_TAB);
        put(8'd0);
        put(8'd31);
        put(8'd128);
        put(8'd255);
        put(CH_LF);
        put(CH_CR);
        issue(REQ_READ, 8'h00, 5'd1, 7'd0, 8'h00);
        put(CH_FF);
        issue(REQ_CLEAR, 8'hFF, 5'd31, 7'd127, 8'hFF);
        issue(REQ_READ, 8'hFF, 5'd1, 7'd1, 8'hFF);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_console_regs(5'd0, 5'd15, 5'd23);
                1: set_console_regs(5'd31, 5'd16, 5'd31);
                2: set_console_regs(CFG_DATA_W'($urandom_range(0, 31)),
                                    CFG_DATA_W'($urandom_range(0, 31)), 5'd0);
                3: set_console_regs(CFG_DATA_W'($urandom_range(0, 31)),
                                    CFG_DATA_W'($urandom_range(0, 31)), 5'd24);
                default: set_console_regs(CFG_DATA_W'($urandom_range(0, 31)),
                                          CFG_DATA_W'($urandom_range(0, 31)),
                                          CFG_DATA_W'($urandom_range(0, 31)));
            endcase
            case (p)
                0: idle_pct = 30;
                1: idle_pct = 0;
                2: idle_pct = 50;
                3: idle_pct = 15;
                4: idle_pct = 60;
                5: idle_pct = 25;
                default: idle_pct = 0;
            endcase
            run_phase(PHASE_ITEMS);
            drain();
        end

        // Catch any stray result
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
